>>> src/uer_pkg.sv
// Shared types and constants for the ultrasonic echo ranger.
// Used by every module of the block but uer_queue; has no dependencies of its own.
package uer_pkg;

    // Input word: one microsecond tick.
    typedef struct packed {
        logic start_req;
        logic echo_level;
    } tick_word_t;

    // Result word: one per accepted tick.
    typedef struct packed {
        logic       trigger_out;
        logic       busy_res;
        logic       done_res;
        logic [9:0] distance;
        logic [1:0] status;
    } result_word_t;

    // Configuration register indexes.
    localparam logic [1:0] REG_UNIT_INCHES = 2'd0;
    localparam logic [1:0] REG_WAIT_LIMIT  = 2'd1;
    localparam logic [1:0] REG_MAX_ECHO    = 2'd2;

    // Measurement status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_NO_ECHO  = 2'd1;
    localparam logic [1:0] STATUS_OVER     = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [15:0] WAIT_LIMIT_RESET = 16'd5900;
    localparam logic [14:0] MAX_ECHO_RESET   = 15'd17700;

    // Reciprocal constants. For any 15-bit dividend, (x * MUL) >> SHIFT is
    // exactly x / 59 and x / 150, since the rounding error stays below one.
    localparam logic [15:0] CM_MUL       = 16'd35545;
    localparam int          CM_SHIFT     = 21;
    localparam logic [15:0] INCH_MUL     = 16'd55925;
    localparam int          INCH_SHIFT   = 23;
    localparam int          PROD_W       = 31;

    // Configuration seen by the front end.
    typedef struct packed {
        logic        unit_inches;
        logic [15:0] wait_limit;
        logic [14:0] max_echo;
    } ranger_cfg_t;

    // Classified tick passed from front end to back end.
    typedef struct packed {
        logic        trigger;
        logic        busy;
        logic        done;
        logic [1:0]  status;
        logic [14:0] dividend;
        logic        inches;
    } job_t;

endpackage

>>> src/ultrasonic_echo_ranger.sv
// Top level of the ultrasonic echo ranger: configuration registers,
// front end, job queue, back end and result queue. Depends on uer_pkg.
//
//   Channel   Handshake               Payload
//   tick      push / full             tick   (start_req, echo_level)
//   result    pop / empty             result (trigger_out .. status)
//   config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One tick word is accepted per cycle while full is low; each produces exactly one
// result word. A word passes the job queue and then the registered reciprocal
// multiplier on its way to the result queue.
// Reset clears the phase machine, the queues and the registers to defaults.
// A stalled result side fills the result queue, then the job queue, then
// raises full; configuration writes are always taken.
module ultrasonic_echo_ranger #(
    parameter int TRIGGER_TICKS = 10,
    parameter int JOB_DEPTH     = 2,
    parameter int RES_DEPTH     = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  uer_pkg::tick_word_t   tick,
    output logic                  empty,
    input  logic                  pop,
    output uer_pkg::result_word_t result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data
);

    uer_pkg::ranger_cfg_t  cfg_reg;
    uer_pkg::job_t         front_job;
    uer_pkg::job_t         queued_job;
    uer_pkg::result_word_t back_word;
    logic                  accept;
    logic                  job_full;
    logic                  job_empty;
    logic                  job_pop;
    logic                  res_push;
    logic                  res_full;

    assign cfg_ready = 1'b1;
    assign full      = job_full;
    assign accept    = push && !job_full;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.unit_inches <= 1'b0;
            cfg_reg.wait_limit  <= uer_pkg::WAIT_LIMIT_RESET;
            cfg_reg.max_echo    <= uer_pkg::MAX_ECHO_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                uer_pkg::REG_UNIT_INCHES: cfg_reg.unit_inches <= cfg_data[0];
                uer_pkg::REG_WAIT_LIMIT:  cfg_reg.wait_limit  <= cfg_data;
                uer_pkg::REG_MAX_ECHO:    cfg_reg.max_echo    <= cfg_data[14:0];
                default:                  cfg_reg             <= cfg_reg;
            endcase
        end
    end

    uer_front #(
        .TRIGGER_TICKS (TRIGGER_TICKS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .tick   (tick),
        .cfg    (cfg_reg),
        .job    (front_job)
    );

    uer_queue #(
        .WIDTH ($bits(uer_pkg::job_t)),
        .DEPTH (JOB_DEPTH)
    ) u_job_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (accept),
        .wr_data (front_job),
        .full    (job_full),
        .pop     (job_pop),
        .rd_data (queued_job),
        .empty   (job_empty)
    );

    uer_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!job_empty),
        .job       (queued_job),
        .job_pop   (job_pop),
        .res_push  (res_push),
        .res_word  (back_word),
        .res_full  (res_full)
    );

    uer_queue #(
        .WIDTH ($bits(uer_pkg::result_word_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (back_word),
        .full    (res_full),
        .pop     (pop),
        .rd_data (result),
        .empty   (empty)
    );

endmodule

>>> src/uer_queue.sv
// Small synchronous FIFO of register entries.
// Generic; used for the job queue and the result queue. No package needed.
module uer_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointer and fill count update, wrapping at the depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> src/uer_front.sv
// Front end: runs the ranging phase machine once per accepted tick.
// Depends on uer_pkg for the word, job and configuration types.
module uer_front #(
    parameter int TRIGGER_TICKS = 10
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  uer_pkg::tick_word_t  tick,
    input  uer_pkg::ranger_cfg_t cfg,
    output uer_pkg::job_t        job
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_TRIG = 2'd1;
    localparam logic [1:0] PH_WAIT = 2'd2;
    localparam logic [1:0] PH_MEAS = 2'd3;

    logic [1:0]  phase_reg, phase_next;
    logic [15:0] count_reg, count_next;
    logic [16:0] count_inc;

    assign count_inc = {1'b0, count_reg} + 17'd1;

    // Classify the tick and advance the phase.
    always_comb
    begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        job          = '0;
        job.inches   = cfg.unit_inches;
        if (accept)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (tick.start_req)
                    begin
                        job.trigger = 1'b1;
                        job.busy    = 1'b1;
                        if (TRIGGER_TICKS <= 1)
                        begin
                            phase_next = PH_WAIT;
                            count_next = '0;
                        end
                        else
                        begin
                            phase_next = PH_TRIG;
                            count_next = 16'd1;
                        end
                    end
                end
                PH_TRIG:
                begin
                    job.trigger = 1'b1;
                    job.busy    = 1'b1;
                    if (count_inc >= 17'(TRIGGER_TICKS))
                    begin
                        phase_next = PH_WAIT;
                        count_next = '0;
                    end
                    else
                    begin
                        count_next = count_inc[15:0];
                    end
                end
                PH_WAIT:
                begin
                    if (tick.echo_level)
                    begin
                        // A zero width limit saturates on the rising tick.
                        if (cfg.max_echo == '0)
                        begin
                            job.done     = 1'b1;
                            job.status   = uer_pkg::STATUS_OVER;
                            job.dividend = cfg.max_echo;
                            phase_next   = PH_IDLE;
                            count_next   = '0;
                        end
                        else
                        begin
                            job.busy   = 1'b1;
                            phase_next = PH_MEAS;
                            count_next = 16'd1;
                        end
                    end
                    else if (count_inc > {1'b0, cfg.wait_limit})
                    begin
                        job.done   = 1'b1;
                        job.status = uer_pkg::STATUS_NO_ECHO;
                        phase_next = PH_IDLE;
                        count_next = '0;
                    end
                    else
                    begin
                        job.busy   = 1'b1;
                        count_next = count_inc[15:0];
                    end
                end
                PH_MEAS:
                begin
                    if (tick.echo_level)
                    begin
                        if (count_inc > {2'b00, cfg.max_echo})
                        begin
                            job.done     = 1'b1;
                            job.status   = uer_pkg::STATUS_OVER;
                            job.dividend = cfg.max_echo;
                            phase_next   = PH_IDLE;
                            count_next   = '0;
                        end
                        else
                        begin
                            job.busy   = 1'b1;
                            count_next = count_inc[15:0];
                        end
                    end
                    else
                    begin
                        // The count never exceeds max_echo here, so 15 bits hold it.
                        job.done     = 1'b1;
                        job.status   = uer_pkg::STATUS_OK;
                        job.dividend = count_reg[14:0];
                        phase_next   = PH_IDLE;
                        count_next   = '0;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                    count_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> src/uer_back.sv
// Back end: converts echo width to distance by reciprocal multiplication.
// Depends on uer_pkg for the job and result types and the reciprocals.
module uer_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  job_valid,
    input  uer_pkg::job_t         job,
    output logic                  job_pop,
    output logic                  res_push,
    output uer_pkg::result_word_t res_word,
    input  logic                  res_full
);

    logic                       valid_reg;
    logic [uer_pkg::PROD_W-1:0] prod_reg;
    uer_pkg::job_t              job_reg;
    logic                       stage_ready;
    logic [15:0]                mul_const;
    logic [uer_pkg::PROD_W-1:0] prod_next;
    logic [uer_pkg::PROD_W-1:0] quot;

    assign stage_ready = !valid_reg || !res_full;
    assign job_pop     = job_valid && stage_ready;

    // Multiply the dividend by the reciprocal of the selected divisor.
    assign mul_const = job.inches ? uer_pkg::INCH_MUL : uer_pkg::CM_MUL;
    assign prod_next = uer_pkg::PROD_W'({16'd0, job.dividend} * {15'd0, mul_const});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (stage_ready)
        begin
            valid_reg <= job_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            prod_reg <= prod_next;
            job_reg  <= job;
        end
    end

    // Shift out the quotient and form the result word.
    assign quot = job_reg.inches ? (prod_reg >> uer_pkg::INCH_SHIFT)
                                 : (prod_reg >> uer_pkg::CM_SHIFT);

    always_comb
    begin
        res_word             = '0;
        res_word.trigger_out = job_reg.trigger;
        res_word.busy_res    = job_reg.busy;
        res_word.done_res    = job_reg.done;
        res_word.distance    = quot[9:0];
        res_word.status      = job_reg.status;
    end

    assign res_push = valid_reg && !res_full;

endmodule

>>> tb/ultrasonic_echo_ranger_checker.sv
// Result checker for the ultrasonic echo ranger: predicts one result word per
// accepted tick word and compares it with the words popped from the block.
// Depends on uer_pkg for the word types, register indexes and status codes.
module ultrasonic_echo_ranger_checker #(
    parameter int TRIGGER_TICKS = 10
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic                  full,
    input  uer_pkg::tick_word_t   tick,
    input  logic                  empty,
    input  logic                  pop,
    input  uer_pkg::result_word_t result,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    output int                    fail_count,
    output int                    pending
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TRIGGER,
        PH_AWAIT,
        PH_MEASURE
    } ranger_phase_t;

    localparam int CM_DIV   = 59;
    localparam int INCH_DIV = 150;

    // Shadow copy of the configuration and of the phase machine.
    logic          inches;
    logic [15:0]   wait_lim;
    logic [14:0]   echo_lim;
    ranger_phase_t phase;
    logic [15:0]   ticks;

    uer_pkg::result_word_t expected_q[$];
    uer_pkg::result_word_t want;

    // Echo width converted to the selected unit.
    function automatic logic [9:0] scaled(int width);
        return 10'(width / (inches ? INCH_DIV : CM_DIV));
    endfunction

    // Advance the phase machine by one tick and return the word it produces.
    function automatic uer_pkg::result_word_t range_tick(uer_pkg::tick_word_t w);
        uer_pkg::result_word_t r;
        int                    nxt;
        r = '0;
        case (phase)
            PH_IDLE:
            begin
                if (w.start_req)
                begin
                    r.trigger_out = 1'b1;
                    r.busy_res    = 1'b1;
                    ticks         = 16'd1;
                    if (TRIGGER_TICKS <= 1)
                    begin
                        phase = PH_AWAIT;
                        ticks = '0;
                    end
                    else
                    begin
                        phase = PH_TRIGGER;
                    end
                end
            end
            PH_TRIGGER:
            begin
                // The echo pin is ignored while the trigger pulse is out.
                r.trigger_out = 1'b1;
                r.busy_res    = 1'b1;
                ticks         = ticks + 16'd1;
                if (int'(ticks) >= TRIGGER_TICKS)
                begin
                    phase = PH_AWAIT;
                    ticks = '0;
                end
            end
            PH_AWAIT:
            begin
                if (w.echo_level)
                begin
                    // The rising tick counts as the first echo tick.
                    if (1 > int'(echo_lim))
                    begin
                        r.done_res = 1'b1;
                        r.status   = uer_pkg::STATUS_OVER;
                        r.distance = scaled(int'(echo_lim));
                        phase      = PH_IDLE;
                        ticks      = '0;
                    end
                    else
                    begin
                        r.busy_res = 1'b1;
                        phase      = PH_MEASURE;
                        ticks      = 16'd1;
                    end
                end
                else
                begin
                    nxt = int'(ticks) + 1;
                    if (nxt > int'(wait_lim))
                    begin
                        r.done_res = 1'b1;
                        r.status   = uer_pkg::STATUS_NO_ECHO;
                        phase      = PH_IDLE;
                        ticks      = '0;
                    end
                    else
                    begin
                        r.busy_res = 1'b1;
                        ticks      = 16'(nxt);
                    end
                end
            end
            default:
            begin
                if (w.echo_level)
                begin
                    nxt = int'(ticks) + 1;
                    if (nxt > int'(echo_lim))
                    begin
                        r.done_res = 1'b1;
                        r.status   = uer_pkg::STATUS_OVER;
                        r.distance = scaled(int'(echo_lim));
                        phase      = PH_IDLE;
                        ticks      = '0;
                    end
                    else
                    begin
                        r.busy_res = 1'b1;
                        ticks      = 16'(nxt);
                    end
                end
                else
                begin
                    r.done_res = 1'b1;
                    r.status   = uer_pkg::STATUS_OK;
                    r.distance = scaled(int'(ticks));
                    phase      = PH_IDLE;
                    ticks      = '0;
                end
            end
        endcase
        return r;
    endfunction

    function automatic void check_field(string name, int exp_val, int act_val);
        if (exp_val != act_val)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            fail_count++;
        end
    endfunction

    // Compare popped words, predict pushed words, then track register writes
    // so that a write applies from the next tick on.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inches     = 1'b0;
            wait_lim   = uer_pkg::WAIT_LIMIT_RESET;
            echo_lim   = uer_pkg::MAX_ECHO_RESET;
            phase      = PH_IDLE;
            ticks      = '0;
            fail_count = 0;
            expected_q.delete();
            pending    = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result word popped with no expected word waiting");
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("trigger_out", want.trigger_out, result.trigger_out);
                    check_field("busy_res", want.busy_res, result.busy_res);
                    check_field("done_res", want.done_res, result.done_res);
                    check_field("distance", want.distance, result.distance);
                    check_field("status", want.status, result.status);
                end
            end
            if (push && !full)
            begin
                expected_q.push_back(range_tick(tick));
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    uer_pkg::REG_UNIT_INCHES: inches   = cfg_data[0];
                    uer_pkg::REG_WAIT_LIMIT:  wait_lim = cfg_data;
                    uer_pkg::REG_MAX_ECHO:    echo_lim = cfg_data[14:0];
                    default:                  ;
                endcase
            end
            pending = expected_q.size();
        end
    end

endmodule

>>> tb/tb_ultrasonic_echo_ranger.sv
// Testbench top for the ultrasonic echo ranger: clock, reset, tick and
// configuration stimulus, random result stalls and the final verdict.
// Depends on uer_pkg, the block and ultrasonic_echo_ranger_checker.
module tb_ultrasonic_echo_ranger;

    localparam int TRIGGER_TICKS = 10;
    localparam int LIMIT_CYCLES  = 3_000_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_TICKS   = 150;
    // Index that maps to no register; writes to it must be ignored.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  push;
    logic                  full;
    uer_pkg::tick_word_t   tick;
    logic                  empty;
    logic                  pop = 1'b0;
    uer_pkg::result_word_t result;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [1:0]            cfg_index;
    logic [15:0]           cfg_data;

    int fail_count;
    int pending;
    int cycles = 0;
    int sent;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    // Current settings, used only to shape the stimulus.
    logic cur_inches;
    int   cur_wait;
    int   cur_max;

    always #5 clk = ~clk;

    ultrasonic_echo_ranger #(
        .TRIGGER_TICKS(TRIGGER_TICKS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .tick      (tick),
        .empty     (empty),
        .pop       (pop),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ultrasonic_echo_ranger_checker #(
        .TRIGGER_TICKS(TRIGGER_TICKS)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .tick       (tick),
        .empty      (empty),
        .pop        (pop),
        .result     (result),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Run limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: pop with a random stall rate.
    always @(negedge clk)
    begin
        pop <= rst_n && ($urandom_range(99) >= rx_idle_pct);
    end

    // Send one tick word, with random idle cycles in front of it.
    task automatic send_tick(input logic s, input logic e);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push           <= 1'b1;
        tick.start_req  <= s;
        tick.echo_level <= e;
        do
            @(posedge clk);
        while (full);
        sent++;
    endtask

    task automatic send_run(input logic s, input logic e, input int n);
        repeat (n) send_tick(s, e);
    endtask

    // Stop sending and wait until every expected word has come back.
    task automatic idle_drain();
        @(negedge clk);
        push <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Write all three registers; unused data bits carry random values.
    task automatic configure(input logic unit, input int wait_ticks, input int max_ticks);
        logic [15:0] data;
        idle_drain();
        data    = 16'($urandom);
        data[0] = unit;
        write_reg(uer_pkg::REG_UNIT_INCHES, data);
        write_reg(uer_pkg::REG_WAIT_LIMIT, 16'(wait_ticks));
        data       = 16'($urandom);
        data[14:0] = 15'(max_ticks);
        write_reg(uer_pkg::REG_MAX_ECHO, data);
        if ($urandom_range(3) == 0)
            write_reg(REG_UNUSED, 16'($urandom));
        cur_inches = unit;
        cur_wait   = wait_ticks;
        cur_max    = max_ticks;
    endtask

    task automatic random_setup();
        int max_ticks;
        if ($urandom_range(7) == 0)
            max_ticks = $urandom_range(400, 100);
        else
            max_ticks = $urandom_range(30);
        configure($urandom_range(1), $urandom_range(24), max_ticks);
    endtask

    // One measurement: start, trigger pulse, echo delay, echo width, low tick.
    // Pins that the block ignores in a phase carry random levels.
    task automatic measure(input int delay, input int width);
        send_tick(1'b1, $urandom_range(1));
        repeat (TRIGGER_TICKS - 1) send_tick($urandom_range(1), $urandom_range(1));
        repeat (delay) send_tick($urandom_range(1), 1'b0);
        repeat (width) send_tick($urandom_range(1), 1'b1);
        send_tick($urandom_range(1), 1'b0);
    endtask

    initial
    begin
        int kind;
        int count;
        push      = 1'b0;
        tick      = '0;
        cfg_valid = 1'b0;
        cfg_index = uer_pkg::REG_UNIT_INCHES;
        cfg_data  = '0;
        rst_n     = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: echo while idle, echo and start during the trigger pulse,
        // saturation with a start on the finishing tick, then a no-echo timeout.
        configure(1'b0, 3, 2);
        send_run(1'b0, 1'b1, 1);
        send_run(1'b1, 1'b1, TRIGGER_TICKS);
        send_run(1'b1, 1'b1, 3);
        send_run(1'b1, 1'b0, TRIGGER_TICKS);
        send_run(1'b0, 1'b0, 4);

        // Zero limits: the rising tick saturates, and one low tick times out.
        configure(1'b1, 0, 0);
        send_run(1'b1, 1'b0, TRIGGER_TICKS);
        send_run(1'b0, 1'b1, 1);
        send_run(1'b1, 1'b0, TRIGGER_TICKS);
        send_run(1'b0, 1'b0, 1);

        // Largest limits with a normal echo ended by a low tick.
        configure(1'b0, 65535, 32767);
        send_run(1'b1, 1'b0, TRIGGER_TICKS);
        send_run(1'b0, 1'b0, 2);
        send_run(1'b0, 1'b1, 120);
        send_run(1'b1, 1'b0, 1);

        // Random measurements under three idling patterns.
        for (int p = 0; p < 3; p++)
        begin
            idle_drain();
            case (p)
                0:
                begin
                    tx_idle_pct = 15;
                    rx_idle_pct = 58;
                end
                1:
                begin
                    tx_idle_pct = 58;
                    rx_idle_pct = 15;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            sent  = 0;
            count = 0;
            while (sent < PHASE_TICKS)
            begin
                if (count % 5 == 0)
                    random_setup();
                count++;
                kind = $urandom_range(99);
                if (kind < 75)
                    measure($urandom_range(cur_wait), $urandom_range(cur_max + 1));
                else if (kind < 90)
                    measure($urandom_range(cur_wait + 3), $urandom_range(cur_max + 3));
                else
                    repeat ($urandom_range(12, 1))
                        send_tick($urandom_range(1), $urandom_range(1));
            end
        end

        idle_drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
